// File: src/svd_2x2_rotation_factors_defines.svh
// Assertion macros for the rotation factor block.
// Each macro expects clk and rst_n in scope.
`ifndef SVD_2X2_ROTATION_FACTORS_DEFINES_SVH
`define SVD_2X2_ROTATION_FACTORS_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SVD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define SVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Check that holds while reset is asserted as well
`define SVD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SVD_ASSERT_NOW(lbl, ante, cons)
`define SVD_ASSERT_NEXT(lbl, ante, cons)
`define SVD_ASSERT_RST(lbl, ante, cons)
`endif
`endif

// File: src/svd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svd_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int EW          = ENTRY_WIDTH;
  // Working width of angles and polynomial terms
  localparam int QW          = FRAC_BITS + 8;
  localparam int OUT_W       = 18;
  localparam int OUT_FRAC    = 16;
  localparam int OSH         = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int LSH         = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  // Quotient bits: integer bit, fraction bits, round bit
  localparam int NQ          = FRAC_BITS + 2;
  localparam int RW          = EW + 2;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    logic vld;
    q_t   theta;
  } svd_ang_t;

  function automatic q_t qc(input real v);
    q_t r;
    if (v >= 0.0) r = QW'($rtoi(v * (2.0 ** FRAC_BITS) + 0.5));
    else          r = -QW'($rtoi(-v * (2.0 ** FRAC_BITS) + 0.5));
    return r;
  endfunction

  localparam q_t HALF_PI = qc(1.5707963267948966);
  localparam q_t AT_C1   = qc(0.9993162682146682);
  localparam q_t AT_C3   = qc(-0.3222835041258624);
  localparam q_t AT_C5   = qc(0.14902466975931372);
  localparam q_t AT_C7   = qc(-0.04085799434591237);
  localparam q_t COS_C2  = qc(-1.0 / 2.0);
  localparam q_t COS_C4  = qc(1.0 / 24.0);
  localparam q_t COS_C6  = qc(-1.0 / 720.0);
  localparam q_t SIN_C3  = qc(-1.0 / 6.0);
  localparam q_t SIN_C5  = qc(1.0 / 120.0);
  localparam q_t SIN_C7  = qc(-1.0 / 5040.0);
  localparam q_t Q_ONE   = q_t'(1) <<< FRAC_BITS;

  // Fixed-point product, rounded half away from zero
  function automatic q_t mulq(input q_t x, input q_t y);
    logic [QW-1:0]   mx;
    logic [QW-1:0]   my;
    logic [2*QW-1:0] p;
    logic [QW-1:0]   pr;
    mx = x[QW-1] ? QW'(-x) : QW'(x);
    my = y[QW-1] ? QW'(-y) : QW'(y);
    p  = mx * my;
    p  = p + ((2*QW)'(1) << (FRAC_BITS - 1));
    pr = QW'(p >> FRAC_BITS);
    return (x[QW-1] ^ y[QW-1]) ? -q_t'(pr) : q_t'(pr);
  endfunction

  // Convert to Q16 and saturate to the output range
  function automatic logic signed [OUT_W-1:0] to_out(input q_t v);
    logic [QW+LSH-1:0] m;
    logic [QW+LSH-1:0] lim;
    m = (QW+LSH)'(v[QW-1] ? QW'(-v) : QW'(v));
    m = ((m + (QW+LSH)'((1 << OSH) >> 1)) >> OSH) << LSH;
    lim = v[QW-1] ? (QW+LSH)'(1 << (OUT_W-1)) : (QW+LSH)'((1 << (OUT_W-1)) - 1);
    if (m > lim) m = lim;
    return v[QW-1] ? -OUT_W'(m) : OUT_W'(m);
  endfunction

endpackage
`default_nettype wire

// File: src/svd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface svd_in_if import svd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [EW-1:0] entry_a;
  logic signed [EW-1:0] entry_b;
  logic signed [EW-1:0] entry_c;
  logic signed [EW-1:0] entry_d;
  modport source (output valid, entry_a, entry_b, entry_c, entry_d, input ready);
  modport sink (input valid, entry_a, entry_b, entry_c, entry_d, output ready);
endinterface
`default_nettype wire

// File: src/svd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface svd_out_if import svd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] cos_left;
  logic signed [OUT_W-1:0] sin_left;
  logic signed [OUT_W-1:0] cos_right;
  logic signed [OUT_W-1:0] sin_right;
  modport source (output valid, cos_left, sin_left, cos_right, sin_right, input ready);
  modport sink (input valid, cos_left, sin_left, cos_right, sin_right, output ready);
endinterface
`default_nettype wire

// File: src/svd_atan.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined arctangent of num/den: operand swap, one quotient bit per
// stage, then a Horner chain with one product per stage.
module svd_atan import svd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  logic signed [EW:0] num,
  input  logic signed [EW:0] den,
  output svd_ang_t           ang
);

  localparam int NP = 7;  // stages after the divider

  logic [EW:0] mn, md;

  // Divider pipeline, index 0 is the swap stage
  logic          dvld_r [NQ+1];
  logic          neg_r  [NQ+1];
  logic          swp_r  [NQ+1];
  logic          zro_r  [NQ+1];
  logic [EW:0]   ma_r   [NQ+1];
  logic [RW-1:0] rem_r  [NQ+1];
  logic [NQ-1:0] quo_r  [NQ+1];

  // Polynomial pipeline
  logic pvld_r [NP];
  logic pneg_r [NP];
  logic pswp_r [NP];
  logic pzro_r [NP];
  q_t   x_r    [NP];
  q_t   xs_r   [NP];
  q_t   t_r    [NP];

  assign mn = num[EW] ? -num : num;
  assign md = den[EW] ? -den : den;

  // Swap so the ratio magnitude stays at most one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else if (en) begin
      dvld_r[0] <= vld_in;
    end
    if (en) begin
      swp_r[0] <= mn > md;
      ma_r[0]  <= (mn > md) ? mn : md;
      rem_r[0] <= RW'((mn > md) ? md : mn);
      quo_r[0] <= '0;
      neg_r[0] <= (num[EW] != den[EW]) && (num != '0) && (den != '0);
      zro_r[0] <= (mn == '0) && (md == '0);
    end
  end

  // One restoring division step per stage
  for (genvar k = 0; k < NQ; k++) begin : g_div
    logic          ge;
    logic [RW-1:0] diff;
    assign ge   = rem_r[k] >= RW'(ma_r[k]);
    assign diff = ge ? rem_r[k] - RW'(ma_r[k]) : rem_r[k];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k+1] <= 1'b0;
      end else if (en) begin
        dvld_r[k+1] <= dvld_r[k];
      end
      if (en) begin
        rem_r[k+1] <= diff << 1;
        quo_r[k+1] <= {quo_r[k][NQ-2:0], ge};
        ma_r[k+1]  <= ma_r[k];
        neg_r[k+1] <= neg_r[k];
        swp_r[k+1] <= swp_r[k];
        zro_r[k+1] <= zro_r[k];
      end
    end
  end

  logic [QW-1:0] xmag;
  assign xmag = QW'(quo_r[NQ][NQ-1:1]) + QW'(quo_r[NQ][0]);

  // Valid and flags advance through the polynomial stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) pvld_r[i] <= 1'b0;
    end else if (en) begin
      pvld_r[0] <= dvld_r[NQ];
      for (int i = 1; i < NP; i++) pvld_r[i] <= pvld_r[i-1];
    end
    if (en) begin
      pneg_r[0] <= neg_r[NQ];
      pswp_r[0] <= swp_r[NQ];
      pzro_r[0] <= zro_r[NQ];
      for (int i = 1; i < NP; i++) begin
        pneg_r[i] <= pneg_r[i-1];
        pswp_r[i] <= pswp_r[i-1];
        pzro_r[i] <= pzro_r[i-1];
        x_r[i]    <= x_r[i-1];
      end
      for (int i = 2; i < NP; i++) begin
        xs_r[i]   <= xs_r[i-1];
      end
      // Signed ratio
      x_r[0]  <= neg_r[NQ] ? -q_t'(xmag) : q_t'(xmag);
      xs_r[0] <= '0;
      t_r[0]  <= '0;
      // Square
      xs_r[1] <= mulq(x_r[0], x_r[0]);
      t_r[1]  <= AT_C7;
      // Horner steps
      t_r[2]  <= AT_C5 + mulq(xs_r[1], t_r[1]);
      t_r[3]  <= AT_C3 + mulq(xs_r[2], t_r[2]);
      t_r[4]  <= AT_C1 + mulq(xs_r[3], t_r[3]);
      t_r[5]  <= mulq(x_r[4], t_r[4]);
      // Undo the swap, or take pi/2 for a zero pair
      if (pzro_r[5])      t_r[6] <= HALF_PI;
      else if (!pswp_r[5]) t_r[6] <= t_r[5];
      else                t_r[6] <= (pneg_r[5] ? -HALF_PI : HALF_PI) - t_r[5];
    end
  end

  assign ang.vld   = pvld_r[NP-1];
  assign ang.theta = t_r[NP-1];

endmodule
`default_nettype wire

// File: src/svd_2x2_rotation_factors.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Payload                                  | Handshake
// in_ch    | in  | entry_a, entry_b, entry_c, entry_d (s32) | valid/ready
// out_ch   | out | cos_left, sin_left, cos_right, sin_right | valid/ready
//
// One matrix per cycle while the output is not stalled; the depth is set by the 18-stage
// quotient pipeline of each arctangent and the product chains that follow.
// Reset (rst_n low, synchronous) clears every valid bit; no data is reset.
// A stalled output freezes the whole pipeline; nothing is dropped or
// repeated, and in_ch.ready falls only while a result waits.
module svd_2x2_rotation_factors import svd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  svd_in_if.sink   in_ch,
  svd_out_if.source out_ch
);
`include "svd_2x2_rotation_factors_defines.svh"

  localparam int NT = 5;  // Taylor stages

  logic en;
  logic vld_s_r;
  logic signed [EW:0] ns_r, ds_r, nd_r, dd_r;
  svd_ang_t ang_s, ang_d;

  logic vld_h_r;
  q_t   th_r [2];

  logic tvld_r [NT];
  q_t   ang_r  [NT][2];
  q_t   sq_r   [NT][2];
  q_t   tc_r   [NT][2];
  q_t   tsn_r  [NT][2];

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] cos_l_r, sin_l_r, cos_r_r, sin_r_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Form the two numerator/denominator pairs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s_r <= 1'b0;
    end else if (en) begin
      vld_s_r <= in_ch.valid;
    end
    if (en) begin
      ns_r <= {in_ch.entry_c[EW-1], in_ch.entry_c} + {in_ch.entry_b[EW-1], in_ch.entry_b};
      ds_r <= {in_ch.entry_d[EW-1], in_ch.entry_d} - {in_ch.entry_a[EW-1], in_ch.entry_a};
      nd_r <= {in_ch.entry_c[EW-1], in_ch.entry_c} - {in_ch.entry_b[EW-1], in_ch.entry_b};
      dd_r <= {in_ch.entry_d[EW-1], in_ch.entry_d} + {in_ch.entry_a[EW-1], in_ch.entry_a};
    end
  end

  svd_atan u_atan_sum (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_s_r),
    .num(ns_r), .den(ds_r), .ang(ang_s)
  );

  svd_atan u_atan_dif (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(vld_s_r),
    .num(nd_r), .den(dd_r), .ang(ang_d)
  );

  // Half difference and half sum, truncated toward zero
  logic signed [QW:0] dif, sum, dif_b, sum_b;
  assign dif   = {ang_s.theta[QW-1], ang_s.theta} - {ang_d.theta[QW-1], ang_d.theta};
  assign sum   = {ang_s.theta[QW-1], ang_s.theta} + {ang_d.theta[QW-1], ang_d.theta};
  assign dif_b = dif + (QW+1)'(dif[QW]);
  assign sum_b = sum + (QW+1)'(sum[QW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_h_r <= 1'b0;
    end else if (en) begin
      vld_h_r <= ang_s.vld;
    end
    if (en) begin
      th_r[0] <= dif_b[QW:1];
      th_r[1] <= sum_b[QW:1];
    end
  end

  // Taylor chains, lane 0 left angle, lane 1 right angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) tvld_r[i] <= 1'b0;
    end else if (en) begin
      tvld_r[0] <= vld_h_r;
      for (int i = 1; i < NT; i++) tvld_r[i] <= tvld_r[i-1];
    end
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        ang_r[0][l] <= th_r[l];
        sq_r[0][l]  <= mulq(th_r[l], th_r[l]);
        tc_r[0][l]  <= COS_C6;
        tsn_r[0][l] <= SIN_C7;
        for (int i = 1; i < NT; i++) begin
          ang_r[i][l] <= ang_r[i-1][l];
          sq_r[i][l]  <= sq_r[i-1][l];
        end
        tc_r[1][l]  <= COS_C4 + mulq(sq_r[0][l], tc_r[0][l]);
        tsn_r[1][l] <= SIN_C5 + mulq(sq_r[0][l], tsn_r[0][l]);
        tc_r[2][l]  <= COS_C2 + mulq(sq_r[1][l], tc_r[1][l]);
        tsn_r[2][l] <= SIN_C3 + mulq(sq_r[1][l], tsn_r[1][l]);
        tc_r[3][l]  <= Q_ONE + mulq(sq_r[2][l], tc_r[2][l]);
        tsn_r[3][l] <= Q_ONE + mulq(sq_r[2][l], tsn_r[2][l]);
        tc_r[4][l]  <= tc_r[3][l];
        tsn_r[4][l] <= mulq(ang_r[3][l], tsn_r[3][l]);
      end
    end
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tvld_r[NT-1];
    end
    if (en) begin
      cos_l_r <= to_out(tc_r[NT-1][0]);
      sin_l_r <= to_out(tsn_r[NT-1][0]);
      cos_r_r <= to_out(tc_r[NT-1][1]);
      sin_r_r <= to_out(tsn_r[NT-1][1]);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.cos_left  = cos_l_r;
  assign out_ch.sin_left  = sin_l_r;
  assign out_ch.cos_right = cos_r_r;
  assign out_ch.sin_right = sin_r_r;

  `SVD_ASSERT_RST(a_rst_clears, !rst_n, !out_valid_r)
  `SVD_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_ch.ready, out_valid_r && $stable(cos_l_r) && $stable(sin_r_r))
  `SVD_ASSERT_NEXT(a_atan_frozen, !en, $stable(ang_s) && $stable(ang_d))
  `SVD_ASSERT_NOW(a_lanes_aligned, 1'b1, ang_s.vld == ang_d.vld)

endmodule
`default_nettype wire
